// ----- rtl/pafc_pkg.sv -----
// Shared widths, register codes and payload types of the point attractor force block.
package pafc_pkg;

  localparam int unsigned DATA_W        = 32;
  localparam int unsigned DT_W          = 16;
  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned MAG_W         = 33;
  localparam int unsigned SQ_W          = 64;
  localparam int unsigned R_W           = 33;
  localparam int unsigned QUO1_W        = 33;
  localparam int unsigned Q_W           = 34;
  localparam int unsigned C_W           = 41;
  localparam int unsigned SPLIT_W       = 24;
  localparam int unsigned CFG_IDX_W     = 3;
  localparam int unsigned LAW_W         = 3;
  localparam int unsigned KIND_W        = 2;

  localparam logic [C_W-1:0] MAG_CAP = 41'h100_0000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POINT_X  = 3'd0,
    CFG_POINT_Y  = 3'd1,
    CFG_STRENGTH = 3'd2,
    CFG_LAW      = 3'd3,
    CFG_ATTR     = 3'd4
  } cfg_idx_e;

  typedef enum logic [LAW_W-1:0] {
    LAW_CONST    = 3'd0,
    LAW_LIN      = 3'd1,
    LAW_INV_LIN  = 3'd2,
    LAW_QUAD     = 3'd3,
    LAW_INV_QUAD = 3'd4
  } law_e;

  typedef enum logic [KIND_W-1:0] {
    ATTR_POS = 2'd0,
    ATTR_VEL = 2'd1,
    ATTR_ACC = 2'd2
  } attr_e;

  typedef enum logic [1:0] {
    MODE_PASS = 2'd0,
    MODE_MUL  = 2'd1,
    MODE_DIV  = 2'd2
  } law_mode_e;

  typedef struct packed {
    logic [DATA_W-1:0] new_x;
    logic [DATA_W-1:0] new_y;
    logic              changed;
    logic [KIND_W-1:0] kind;
  } res_t;

endpackage

// ----- rtl/pafc_sqrt_cell.sv -----
// One step of the bitwise integer square root, one root bit per cell.
module pafc_sqrt_cell #(
  parameter int unsigned STEP   = 0,
  parameter int unsigned SIDE_W = 1
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic [pafc_pkg::SQ_W-1:0] rad_i,
  input  logic [pafc_pkg::SQ_W-1:0] root_i,
  input  logic [SIDE_W-1:0]         side_i,
  output logic                      valid_o,
  output logic [pafc_pkg::SQ_W-1:0] rad_o,
  output logic [pafc_pkg::SQ_W-1:0] root_o,
  output logic [SIDE_W-1:0]         side_o
);

  localparam int unsigned SqW    = pafc_pkg::SQ_W;
  localparam int unsigned BitPos = SqW - 2 - 2 * STEP;
  localparam logic [SqW-1:0] StepBit = SqW'(1) << BitPos;

  logic           valid_q;
  logic [SqW-1:0] rad_q, root_q;
  logic [SIDE_W-1:0] side_q;
  logic [SqW-1:0] trial;
  logic           take;

  assign trial = root_i + StepBit;
  assign take  = rad_i >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rad_q  <= take ? rad_i - trial : rad_i;
      root_q <= take ? (root_i >> 1) + StepBit : root_i >> 1;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign rad_o   = rad_q;
  assign root_o  = root_q;
  assign side_o  = side_q;

endmodule

// ----- rtl/pafc_div_cell.sv -----
// One restoring division step on two dividends sharing one divisor.
module pafc_div_cell #(
  parameter int unsigned REM_W  = 64,
  parameter int unsigned DEN_W  = 33,
  parameter int unsigned QUO_W  = 33,
  parameter int unsigned QBIT   = 0,
  parameter int unsigned SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [REM_W-1:0]  rem_a_i,
  input  logic [REM_W-1:0]  rem_b_i,
  input  logic [DEN_W-1:0]  den_i,
  input  logic [QUO_W-1:0]  quo_a_i,
  input  logic [QUO_W-1:0]  quo_b_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [REM_W-1:0]  rem_a_o,
  output logic [REM_W-1:0]  rem_b_o,
  output logic [DEN_W-1:0]  den_o,
  output logic [QUO_W-1:0]  quo_a_o,
  output logic [QUO_W-1:0]  quo_b_o,
  output logic [SIDE_W-1:0] side_o
);

  localparam int unsigned CmpW = REM_W + DEN_W;
  localparam logic [QUO_W-1:0] QuoBit = QUO_W'(1) << QBIT;

  logic              valid_q;
  logic [REM_W-1:0]  rem_a_q, rem_b_q;
  logic [DEN_W-1:0]  den_q;
  logic [QUO_W-1:0]  quo_a_q, quo_b_q;
  logic [SIDE_W-1:0] side_q;
  logic [CmpW-1:0]   den_sh;
  logic              take_a, take_b;

  assign den_sh = CmpW'(den_i) << QBIT;
  assign take_a = CmpW'(rem_a_i) >= den_sh;
  assign take_b = CmpW'(rem_b_i) >= den_sh;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_a_q <= take_a ? rem_a_i - den_sh[REM_W-1:0] : rem_a_i;
      rem_b_q <= take_b ? rem_b_i - den_sh[REM_W-1:0] : rem_b_i;
      quo_a_q <= take_a ? (quo_a_i | QuoBit) : quo_a_i;
      quo_b_q <= take_b ? (quo_b_i | QuoBit) : quo_b_i;
      den_q   <= den_i;
      side_q  <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign rem_a_o = rem_a_q;
  assign rem_b_o = rem_b_q;
  assign den_o   = den_q;
  assign quo_a_o = quo_a_q;
  assign quo_b_o = quo_b_q;
  assign side_o  = side_q;

endmodule

// ----- rtl/pafc_law_stage.sv -----
// One application of the distance law: saturating multiply or divide by q, or pass.
module pafc_law_stage #(
  parameter int unsigned FRAC_BITS = pafc_pkg::FRAC_BITS_DEF,
  parameter int unsigned SIDE_W    = 1
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  pafc_pkg::law_mode_e      mode_i,
  input  logic [pafc_pkg::C_W-1:0] c_a_i,
  input  logic [pafc_pkg::C_W-1:0] c_b_i,
  input  logic [pafc_pkg::Q_W-1:0] q_i,
  input  logic [SIDE_W-1:0]        side_i,
  output logic                     valid_o,
  output logic [pafc_pkg::C_W-1:0] c_a_o,
  output logic [pafc_pkg::C_W-1:0] c_b_o,
  output logic [pafc_pkg::Q_W-1:0] q_o,
  output logic [SIDE_W-1:0]        side_o
);

  localparam int unsigned CW     = pafc_pkg::C_W;
  localparam int unsigned QW     = pafc_pkg::Q_W;
  localparam int unsigned SplitW = pafc_pkg::SPLIT_W;
  localparam int unsigned LoW    = SplitW + QW;
  localparam int unsigned HiW    = CW - SplitW + QW;
  localparam int unsigned SumW   = CW + QW;
  localparam int unsigned DivW   = CW + FRAC_BITS;
  localparam int unsigned OvfSh  = pafc_pkg::SQ_W - FRAC_BITS;
  localparam int unsigned InW    = 2 * LoW + 2 * HiW + 2 + 2 * CW + SIDE_W;
  localparam logic [CW-1:0] Cap  = pafc_pkg::MAG_CAP;

  // prep stage: partial products and dividends
  logic              pre_valid_q;
  logic [LoW-1:0]    lo_a_q, lo_b_q;
  logic [HiW-1:0]    hi_a_q, hi_b_q;
  logic              ovf_a_q, ovf_b_q;
  logic [CW-1:0]     a_q, b_q;
  logic [DivW-1:0]   div_a_q, div_b_q;
  logic [QW-1:0]     q_q;
  logic [SIDE_W-1:0] side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_valid_q <= 1'b0;
    end else if (en_i) begin
      pre_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lo_a_q  <= LoW'(c_a_i[SplitW-1:0]) * LoW'(q_i);
      lo_b_q  <= LoW'(c_b_i[SplitW-1:0]) * LoW'(q_i);
      hi_a_q  <= HiW'(c_a_i[CW-1:SplitW]) * HiW'(q_i);
      hi_b_q  <= HiW'(c_b_i[CW-1:SplitW]) * HiW'(q_i);
      ovf_a_q <= |(c_a_i >> OvfSh);
      ovf_b_q <= |(c_b_i >> OvfSh);
      a_q     <= c_a_i;
      b_q     <= c_b_i;
      div_a_q <= DivW'(c_a_i) << FRAC_BITS;
      div_b_q <= DivW'(c_b_i) << FRAC_BITS;
      q_q     <= q_i;
      side_q  <= side_i;
    end
  end

  // divider chain, one quotient bit per cell
  logic            ch_valid [0:CW];
  logic [DivW-1:0] ch_rem_a [0:CW];
  logic [DivW-1:0] ch_rem_b [0:CW];
  logic [QW-1:0]   ch_den   [0:CW];
  logic [CW-1:0]   ch_quo_a [0:CW];
  logic [CW-1:0]   ch_quo_b [0:CW];
  logic [InW-1:0]  ch_side  [0:CW];

  assign ch_valid[0] = pre_valid_q;
  assign ch_rem_a[0] = div_a_q;
  assign ch_rem_b[0] = div_b_q;
  assign ch_den[0]   = q_q;
  assign ch_quo_a[0] = '0;
  assign ch_quo_b[0] = '0;
  assign ch_side[0]  = {lo_a_q, hi_a_q, lo_b_q, hi_b_q, ovf_a_q, ovf_b_q, a_q, b_q, side_q};

  for (genvar k = 0; k < CW; k++) begin : g_div
    pafc_div_cell #(
      .REM_W (DivW),
      .DEN_W (QW),
      .QUO_W (CW),
      .QBIT  (CW - 1 - k),
      .SIDE_W(InW)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en_i),
      .valid_i(ch_valid[k]),
      .rem_a_i(ch_rem_a[k]),
      .rem_b_i(ch_rem_b[k]),
      .den_i  (ch_den[k]),
      .quo_a_i(ch_quo_a[k]),
      .quo_b_i(ch_quo_b[k]),
      .side_i (ch_side[k]),
      .valid_o(ch_valid[k+1]),
      .rem_a_o(ch_rem_a[k+1]),
      .rem_b_o(ch_rem_b[k+1]),
      .den_o  (ch_den[k+1]),
      .quo_a_o(ch_quo_a[k+1]),
      .quo_b_o(ch_quo_b[k+1]),
      .side_o (ch_side[k+1])
    );
  end

  // final select
  logic [LoW-1:0]    e_lo_a, e_lo_b;
  logic [HiW-1:0]    e_hi_a, e_hi_b;
  logic              e_ovf_a, e_ovf_b;
  logic [CW-1:0]     e_a, e_b;
  logic [SIDE_W-1:0] e_side;

  assign {e_lo_a, e_hi_a, e_lo_b, e_hi_b, e_ovf_a, e_ovf_b, e_a, e_b, e_side} = ch_side[CW];

  function automatic logic [CW-1:0] mul_fin(input logic [LoW-1:0] lo, input logic [HiW-1:0] hi);
    logic [SumW-1:0] sum;
    sum = (SumW'(lo) + (SumW'(hi) << SplitW)) >> FRAC_BITS;
    return (sum > SumW'(Cap)) ? Cap : sum[CW-1:0];
  endfunction

  function automatic logic [CW-1:0] div_fin(input logic ovf, input logic [CW-1:0] quo);
    return (ovf || quo > Cap) ? Cap : quo;
  endfunction

  function automatic logic [CW-1:0] pass_fin(input logic [CW-1:0] c);
    return (c > Cap) ? Cap : c;
  endfunction

  logic [CW-1:0] res_a, res_b;

  always_comb begin
    case (mode_i)
      pafc_pkg::MODE_MUL: begin
        res_a = mul_fin(e_lo_a, e_hi_a);
        res_b = mul_fin(e_lo_b, e_hi_b);
      end
      pafc_pkg::MODE_DIV: begin
        res_a = div_fin(e_ovf_a, ch_quo_a[CW]);
        res_b = div_fin(e_ovf_b, ch_quo_b[CW]);
      end
      default: begin
        res_a = pass_fin(e_a);
        res_b = pass_fin(e_b);
      end
    endcase
  end

  logic              out_valid_q;
  logic [CW-1:0]     out_a_q, out_b_q;
  logic [QW-1:0]     out_q_q;
  logic [SIDE_W-1:0] out_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en_i) begin
      out_valid_q <= ch_valid[CW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      out_a_q    <= res_a;
      out_b_q    <= res_b;
      out_q_q    <= ch_den[CW];
      out_side_q <= e_side;
    end
  end

  assign valid_o = out_valid_q;
  assign c_a_o   = out_a_q;
  assign c_b_o   = out_b_q;
  assign q_o     = out_q_q;
  assign side_o  = out_side_q;

endmodule

// ----- rtl/point_attractor_force.sv -----
// Point attractor force: fixed-point pull toward a configured point, one particle per beat.
// Pipeline from an accepted input beat to out_valid_o: 3 front stages,
// 32 square-root cells, 33 divider cells, two law stages and the output register.
// Throughput: one beat per cycle while in_stall_o is low; the chains hold while it is high.
// A one-entry skid behind the output register holds one result while the output stalls.
// Reset: rst_ni low clears all valid bits; registers return to point 0, strength 0,
// linear law, velocity attribute.
module point_attractor_force #(
  parameter int unsigned FRAC_BITS = pafc_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [pafc_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [pafc_pkg::DATA_W-1:0]      cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic signed [pafc_pkg::DATA_W-1:0] particle_x_i,
  input  logic signed [pafc_pkg::DATA_W-1:0] particle_y_i,
  input  logic signed [pafc_pkg::DATA_W-1:0] attr_x_i,
  input  logic signed [pafc_pkg::DATA_W-1:0] attr_y_i,
  input  logic [pafc_pkg::DT_W-1:0]        step_time_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic signed [pafc_pkg::DATA_W-1:0] new_attr_x_o,
  output logic signed [pafc_pkg::DATA_W-1:0] new_attr_y_o,
  output logic                             changed_o,
  output logic [pafc_pkg::KIND_W-1:0]      attribute_kind_o
);

  localparam int unsigned DataW   = pafc_pkg::DATA_W;
  localparam int unsigned DtW     = pafc_pkg::DT_W;
  localparam int unsigned MagW    = pafc_pkg::MAG_W;
  localparam int unsigned SqW     = pafc_pkg::SQ_W;
  localparam int unsigned RW      = pafc_pkg::R_W;
  localparam int unsigned Quo1W   = pafc_pkg::QUO1_W;
  localparam int unsigned QW      = pafc_pkg::Q_W;
  localparam int unsigned CW      = pafc_pkg::C_W;
  localparam int unsigned SqSteps = SqW / 2;
  localparam int unsigned SqSideW = 1 + 2 * SqW + 3 * DataW + 2;
  localparam int unsigned DvSideW = 1 + 3 * DataW + 2;
  localparam int unsigned LwSideW = 2 * DataW + 2;
  localparam int unsigned SumW    = CW + 1;
  localparam logic [QW-1:0] QOne  = QW'(1) << FRAC_BITS;

  // configuration registers
  logic signed [DataW-1:0] point_x_q, point_y_q, strength_q;
  logic [pafc_pkg::LAW_W-1:0]  law_q;
  logic [pafc_pkg::KIND_W-1:0] attr_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      point_x_q  <= '0;
      point_y_q  <= '0;
      strength_q <= '0;
      law_q      <= pafc_pkg::LAW_LIN;
      attr_q     <= pafc_pkg::ATTR_VEL;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        pafc_pkg::CFG_POINT_X:  point_x_q  <= cfg_data_i;
        pafc_pkg::CFG_POINT_Y:  point_y_q  <= cfg_data_i;
        pafc_pkg::CFG_STRENGTH: strength_q <= cfg_data_i;
        pafc_pkg::CFG_LAW:      law_q      <= cfg_data_i[pafc_pkg::LAW_W-1:0];
        pafc_pkg::CFG_ATTR:     attr_q     <= cfg_data_i[pafc_pkg::KIND_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline advances whenever the skid entry is free
  logic adv;
  logic skid_valid_q;

  assign adv        = !skid_valid_q;
  assign in_stall_o = skid_valid_q;

  // stage 0: offsets and magnitudes
  logic signed [MagW-1:0] dx, dy;
  logic [MagW-1:0] mx0_q, my0_q;
  logic            negx0_q, negy0_q, v0_q;
  logic [DataW-1:0] ax0_q, ay0_q;
  logic [DtW-1:0]  dt0_q;

  assign dx = {point_x_q[DataW-1], point_x_q} - {particle_x_i[DataW-1], particle_x_i};
  assign dy = {point_y_q[DataW-1], point_y_q} - {particle_y_i[DataW-1], particle_y_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (adv) begin
      v0_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mx0_q   <= dx[MagW-1] ? MagW'(-dx) : MagW'(dx);
      my0_q   <= dy[MagW-1] ? MagW'(-dy) : MagW'(dy);
      negx0_q <= dx[MagW-1];
      negy0_q <= dy[MagW-1];
      ax0_q   <= attr_x_i;
      ay0_q   <= attr_y_i;
      dt0_q   <= step_time_i;
    end
  end

  // stage 1: squares and scaled strength
  logic            shift0;
  logic [DataW-1:0] sx, sy, smag;
  logic [DataW+DtW-1:0] pfull;
  logic            v1_q, shift1_q, negx1_q, negy1_q;
  logic [SqW-1:0]  sqx1_q, sqy1_q;
  logic [MagW-1:0] mx1_q, my1_q;
  logic [DataW-1:0] p1_q, ax1_q, ay1_q;

  assign shift0 = (|mx0_q[MagW-1:MagW-2]) || (|my0_q[MagW-1:MagW-2]);
  assign sx     = shift0 ? DataW'(mx0_q >> 1) : DataW'(mx0_q);
  assign sy     = shift0 ? DataW'(my0_q >> 1) : DataW'(my0_q);
  assign smag   = strength_q[DataW-1] ? DataW'(-strength_q) : DataW'(strength_q);
  assign pfull  = (DataW+DtW)'(smag) * (DataW+DtW)'(dt0_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (adv) begin
      v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sqx1_q   <= SqW'(sx) * SqW'(sx);
      sqy1_q   <= SqW'(sy) * SqW'(sy);
      p1_q     <= DataW'(pfull >> DtW);
      shift1_q <= shift0;
      mx1_q    <= mx0_q;
      my1_q    <= my0_q;
      negx1_q  <= negx0_q;
      negy1_q  <= negy0_q;
      ax1_q    <= ax0_q;
      ay1_q    <= ay0_q;
    end
  end

  // stage 2: radicand and dividends
  logic [SqW:0]   prod_x, prod_y;
  logic           v2_q, shift2_q, negx2_q, negy2_q;
  logic [SqW-1:0] rad2_q, numx2_q, numy2_q;
  logic [DataW-1:0] p2_q, ax2_q, ay2_q;

  assign prod_x = (SqW+1)'(p1_q) * (SqW+1)'(mx1_q);
  assign prod_y = (SqW+1)'(p1_q) * (SqW+1)'(my1_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (adv) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rad2_q   <= sqx1_q + sqy1_q;
      numx2_q  <= prod_x[SqW-1:0];
      numy2_q  <= prod_y[SqW-1:0];
      p2_q     <= p1_q;
      shift2_q <= shift1_q;
      negx2_q  <= negx1_q;
      negy2_q  <= negy1_q;
      ax2_q    <= ax1_q;
      ay2_q    <= ay1_q;
    end
  end

  // square-root chain
  logic               sq_valid [0:SqSteps];
  logic [SqW-1:0]     sq_rad   [0:SqSteps];
  logic [SqW-1:0]     sq_root  [0:SqSteps];
  logic [SqSideW-1:0] sq_side  [0:SqSteps];

  assign sq_valid[0] = v2_q;
  assign sq_rad[0]   = rad2_q;
  assign sq_root[0]  = '0;
  assign sq_side[0]  = {shift2_q, numx2_q, numy2_q, p2_q, ax2_q, ay2_q, negx2_q, negy2_q};

  for (genvar k = 0; k < SqSteps; k++) begin : g_sqrt
    pafc_sqrt_cell #(
      .STEP  (k),
      .SIDE_W(SqSideW)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .valid_i(sq_valid[k]),
      .rad_i  (sq_rad[k]),
      .root_i (sq_root[k]),
      .side_i (sq_side[k]),
      .valid_o(sq_valid[k+1]),
      .rad_o  (sq_rad[k+1]),
      .root_o (sq_root[k+1]),
      .side_o (sq_side[k+1])
    );
  end

  logic            s_shift, s_negx, s_negy, s_rzero;
  logic [SqW-1:0]  s_numx, s_numy;
  logic [DataW-1:0] s_p, s_ax, s_ay, s_root;
  logic [RW-1:0]   s_r;

  assign {s_shift, s_numx, s_numy, s_p, s_ax, s_ay, s_negx, s_negy} = sq_side[SqSteps];
  assign s_root  = sq_root[SqSteps][DataW-1:0];
  assign s_r     = s_shift ? {s_root, 1'b0} : {1'b0, s_root};
  assign s_rzero = (s_root == '0);

  // direction divider chain: p * |d| / r
  logic               dv_valid [0:Quo1W];
  logic [SqW-1:0]     dv_rem_a [0:Quo1W];
  logic [SqW-1:0]     dv_rem_b [0:Quo1W];
  logic [RW-1:0]      dv_den   [0:Quo1W];
  logic [Quo1W-1:0]   dv_quo_a [0:Quo1W];
  logic [Quo1W-1:0]   dv_quo_b [0:Quo1W];
  logic [DvSideW-1:0] dv_side  [0:Quo1W];

  assign dv_valid[0] = sq_valid[SqSteps];
  assign dv_rem_a[0] = s_numx;
  assign dv_rem_b[0] = s_numy;
  assign dv_den[0]   = s_r;
  assign dv_quo_a[0] = '0;
  assign dv_quo_b[0] = '0;
  assign dv_side[0]  = {s_rzero, s_p, s_ax, s_ay, s_negx, s_negy};

  for (genvar k = 0; k < Quo1W; k++) begin : g_div
    pafc_div_cell #(
      .REM_W (SqW),
      .DEN_W (RW),
      .QUO_W (Quo1W),
      .QBIT  (Quo1W - 1 - k),
      .SIDE_W(DvSideW)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .valid_i(dv_valid[k]),
      .rem_a_i(dv_rem_a[k]),
      .rem_b_i(dv_rem_b[k]),
      .den_i  (dv_den[k]),
      .quo_a_i(dv_quo_a[k]),
      .quo_b_i(dv_quo_b[k]),
      .side_i (dv_side[k]),
      .valid_o(dv_valid[k+1]),
      .rem_a_o(dv_rem_a[k+1]),
      .rem_b_o(dv_rem_b[k+1]),
      .den_o  (dv_den[k+1]),
      .quo_a_o(dv_quo_a[k+1]),
      .quo_b_o(dv_quo_b[k+1]),
      .side_o (dv_side[k+1])
    );
  end

  logic            d_rzero, d_negx, d_negy;
  logic [DataW-1:0] d_p, d_ax, d_ay;
  logic [CW-1:0]   d_cx, d_cy;
  logic [QW-1:0]   d_r, d_q;

  assign {d_rzero, d_p, d_ax, d_ay, d_negx, d_negy} = dv_side[Quo1W];
  assign d_r  = QW'(dv_den[Quo1W]);
  // zero distance: whole pull along +x at unit q
  assign d_cx = d_rzero ? CW'(d_p) : CW'(dv_quo_a[Quo1W]);
  assign d_cy = d_rzero ? '0 : CW'(dv_quo_b[Quo1W]);
  assign d_q  = (d_rzero || d_r < QOne) ? QOne : d_r;

  // distance law: pass for the constant law, applied once for linear laws, twice for quadratic
  pafc_pkg::law_mode_e mode1, mode2;

  always_comb begin
    case (law_q)
      pafc_pkg::LAW_LIN, pafc_pkg::LAW_QUAD:         mode1 = pafc_pkg::MODE_MUL;
      pafc_pkg::LAW_INV_LIN, pafc_pkg::LAW_INV_QUAD: mode1 = pafc_pkg::MODE_DIV;
      default:                                       mode1 = pafc_pkg::MODE_PASS;
    endcase
    case (law_q)
      pafc_pkg::LAW_QUAD:     mode2 = pafc_pkg::MODE_MUL;
      pafc_pkg::LAW_INV_QUAD: mode2 = pafc_pkg::MODE_DIV;
      default:                mode2 = pafc_pkg::MODE_PASS;
    endcase
  end

  logic               l1_valid, l2_valid;
  logic [CW-1:0]      l1_cx, l1_cy, l2_cx, l2_cy;
  logic [QW-1:0]      l1_q;
  logic [LwSideW-1:0] l1_side, l2_side;

  pafc_law_stage #(
    .FRAC_BITS(FRAC_BITS),
    .SIDE_W   (LwSideW)
  ) u_law1 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .valid_i(dv_valid[Quo1W]),
    .mode_i (mode1),
    .c_a_i  (d_cx),
    .c_b_i  (d_cy),
    .q_i    (d_q),
    .side_i ({d_ax, d_ay, d_negx, d_negy}),
    .valid_o(l1_valid),
    .c_a_o  (l1_cx),
    .c_b_o  (l1_cy),
    .q_o    (l1_q),
    .side_o (l1_side)
  );

  pafc_law_stage #(
    .FRAC_BITS(FRAC_BITS),
    .SIDE_W   (LwSideW)
  ) u_law2 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .valid_i(l1_valid),
    .mode_i (mode2),
    .c_a_i  (l1_cx),
    .c_b_i  (l1_cy),
    .q_i    (l1_q),
    .side_i (l1_side),
    .valid_o(l2_valid),
    .c_a_o  (l2_cx),
    .c_b_o  (l2_cy),
    .q_o    (),
    .side_o (l2_side)
  );

  // apply increment and saturate; zero strength passes the attribute unchanged
  logic            f_negx, f_negy;
  logic [DataW-1:0] f_ax, f_ay;
  pafc_pkg::res_t  f_res;

  assign {f_ax, f_ay, f_negx, f_negy} = l2_side;

  function automatic logic [DataW-1:0] apply_sat(input logic [DataW-1:0] a,
                                                input logic [CW-1:0] c,
                                                input logic sub);
    logic signed [SumW-1:0] s;
    s = sub ? $signed({{(SumW-DataW){a[DataW-1]}}, a}) - $signed(SumW'(c))
            : $signed({{(SumW-DataW){a[DataW-1]}}, a}) + $signed(SumW'(c));
    if (s > $signed(SumW'(32'h7fff_ffff))) begin
      return 32'h7fff_ffff;
    end
    if (s < -$signed(SumW'(33'h1_0000_0000)) + $signed(SumW'(32'h8000_0000))) begin
      return 32'h8000_0000;
    end
    return s[DataW-1:0];
  endfunction

  always_comb begin
    f_res.kind = (attr_q == pafc_pkg::KIND_W'(3)) ? pafc_pkg::ATTR_VEL : attr_q;
    if (strength_q == '0) begin
      f_res.new_x   = f_ax;
      f_res.new_y   = f_ay;
      f_res.changed = 1'b0;
    end else begin
      f_res.new_x   = apply_sat(f_ax, l2_cx, strength_q[DataW-1] != f_negx);
      f_res.new_y   = apply_sat(f_ay, l2_cy, strength_q[DataW-1] != f_negy);
      f_res.changed = 1'b1;
    end
  end

  // output register and skid entry
  logic           out_valid_q;
  pafc_pkg::res_t out_q, skid_q;
  logic           take_out;

  assign take_out = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (take_out) begin
      out_valid_q  <= skid_valid_q || l2_valid;
      skid_valid_q <= 1'b0;
    end else if (l2_valid && adv) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_out) begin
      out_q <= skid_valid_q ? skid_q : f_res;
    end else if (l2_valid && adv) begin
      skid_q <= f_res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign new_attr_x_o     = out_q.new_x;
  assign new_attr_y_o     = out_q.new_y;
  assign changed_o        = out_q.changed;
  assign attribute_kind_o = out_q.kind;

  a_skid_needs_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry filled while output register empty");

  a_skid_fill_on_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_valid_q) |-> $past(out_valid_q && out_stall_i))
    else $error("skid entry filled without an output stall");

  a_root_width : assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_valid[SqSteps] |-> (sq_root[SqSteps][SqW-1:DataW] == '0))
    else $error("square root exceeds 32 bits");

  a_no_accept_when_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_valid_q && out_stall_i) |=> skid_valid_q)
    else $error("skid entry lost while output stalled");

endmodule
